// ----- src/jlv_pkg.sv -----
// jlv_pkg: shared types and constants for the json literal validator
// holds the number automaton phase codes, keyword tables and the state struct
// no dependencies
`timescale 1ns / 1ps

package jlv_pkg;

   localparam int KW_COUNT = 3;
   localparam int KW_SLOTS = 8;

   // number automaton phases
   localparam logic [3:0] PH_START  = 4'd0;
   localparam logic [3:0] PH_MINUS  = 4'd1;
   localparam logic [3:0] PH_ZERO   = 4'd2;
   localparam logic [3:0] PH_INT    = 4'd3;
   localparam logic [3:0] PH_DOT    = 4'd4;
   localparam logic [3:0] PH_FRAC   = 4'd5;
   localparam logic [3:0] PH_EXP    = 4'd6;
   localparam logic [3:0] PH_EXPSGN = 4'd7;
   localparam logic [3:0] PH_EXPDIG = 4'd8;
   localparam logic [3:0] PH_DEAD   = 4'd9;

   localparam logic [2:0] KW_ALL  = 3'b111;
   localparam logic [2:0] POS_MAX = 3'd7;

   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_DOT   = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_E = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;

   // keyword text, bit 0 true, bit 1 false, bit 2 null; padded to eight slots
   localparam logic [7:0] KW_TEXT [KW_COUNT][KW_SLOTS] = '{
      '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e",   8'h00, 8'h00, 8'h00},
      '{"n", "u", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd4, 3'd5, 3'd4};

   typedef struct packed {
      logic [3:0] number_phase;
      logic [2:0] keyword_alive;
      logic [2:0] byte_position;
   } jlv_state_type;

   localparam jlv_state_type STATE_RESET = '{
      number_phase:  PH_START,
      keyword_alive: KW_ALL,
      byte_position: 3'd0
   };

endpackage

// ----- src/jlv_step.sv -----
// jlv_step: one byte step of the number automaton and the keyword matcher
// combinational; gives the next state and the verdict if this byte ends the literal
// depends on jlv_pkg
`timescale 1ns / 1ps

module jlv_step (
   input  jlv_pkg::jlv_state_type cur_state,
   input  logic [7:0]             char_byte,
   output jlv_pkg::jlv_state_type next_state,
   output logic                   literal_ok
);
   import jlv_pkg::*;

   logic       is_digit;
   logic       is_exp;
   logic       is_sign;
   logic [3:0] phase_next;
   logic [2:0] alive_next;
   logic [2:0] pos_next;
   logic       kw_ok;
   logic       num_ok;

   always_comb begin
      is_digit = char_byte inside {[CH_ZERO:CH_NINE]};
      is_exp   = (char_byte == CH_LOW_E) || (char_byte == CH_UP_E);
      is_sign  = (char_byte == CH_PLUS) || (char_byte == CH_MINUS);
   end

   always_comb begin
      phase_next = PH_DEAD;
      case (cur_state.number_phase)
         PH_START: begin
            if (char_byte == CH_MINUS) phase_next = PH_MINUS;
            else if (char_byte == CH_ZERO) phase_next = PH_ZERO;
            else if (is_digit) phase_next = PH_INT;
         end
         PH_MINUS: begin
            if (char_byte == CH_ZERO) phase_next = PH_ZERO;
            else if (is_digit) phase_next = PH_INT;
         end
         PH_ZERO: begin
            if (char_byte == CH_DOT) phase_next = PH_DOT;
            else if (is_exp) phase_next = PH_EXP;
         end
         PH_INT: begin
            if (is_digit) phase_next = PH_INT;
            else if (char_byte == CH_DOT) phase_next = PH_DOT;
            else if (is_exp) phase_next = PH_EXP;
         end
         PH_DOT: begin
            if (is_digit) phase_next = PH_FRAC;
         end
         PH_FRAC: begin
            if (is_digit) phase_next = PH_FRAC;
            else if (is_exp) phase_next = PH_EXP;
         end
         PH_EXP: begin
            if (is_sign) phase_next = PH_EXPSGN;
            else if (is_digit) phase_next = PH_EXPDIG;
         end
         PH_EXPSGN, PH_EXPDIG: begin
            if (is_digit) phase_next = PH_EXPDIG;
         end
         default: begin
            phase_next = PH_DEAD;
         end
      endcase
   end

   always_comb begin
      pos_next = (cur_state.byte_position < POS_MAX) ?
                 cur_state.byte_position + 3'd1 : POS_MAX;
      kw_ok = 1'b0;
      for (int k = 0; k < KW_COUNT; k++) begin
         alive_next[k] = cur_state.keyword_alive[k]
                         && (cur_state.byte_position < KW_LEN[k])
                         && (KW_TEXT[k][cur_state.byte_position] == char_byte);
         if (alive_next[k] && (pos_next == KW_LEN[k])) kw_ok = 1'b1;
      end
      num_ok = (phase_next == PH_ZERO) || (phase_next == PH_INT)
               || (phase_next == PH_FRAC) || (phase_next == PH_EXPDIG);
   end

   assign next_state.number_phase  = phase_next;
   assign next_state.keyword_alive = alive_next;
   assign next_state.byte_position = pos_next;
   assign literal_ok               = kw_ok || num_ok;

endmodule

// ----- src/json_literal_validator.sv -----
// json_literal_validator: top level, input word register, literal state and result register
// depends on jlv_pkg and jlv_step
`timescale 1ns / 1ps

// Usage
// req channel: one byte of a bare json literal per word, req_is_final set on
// its last byte. rsp channel: one word per literal, rsp_literal_ok is 1 when the
// literal is exactly true, false, null or a json number.
// Both channels: a word moves on a rising edge with valid high and stall low.
// Throughput: one byte per cycle while req_stall is low, set by the state update
// that runs from the input word register into the literal state.
// A final byte passes the input word register, then the result register, before rsp.
// Bytes that are not final produce no rsp word.
// A stalled rsp holds its word; the input register still drains non-final
// bytes, and req_stall rises only when a final byte meets a full result
// register that is being stalled.
// Reset (synchronous, active high) empties both registers and returns the
// literal state to nothing seen; each final byte also returns it there.

module json_literal_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_byte,
   input  logic       req_is_final,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_literal_ok
);
   import jlv_pkg::*;

   logic          in_valid_ff, in_valid_in;
   logic [7:0]    in_byte_ff,  in_byte_in;
   logic          in_final_ff, in_final_in;
   jlv_state_type state_ff,    state_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_ok_ff,    out_ok_in;

   jlv_state_type step_state;
   logic          step_ok;
   logic          out_free;
   logic          step_go;

   jlv_step u_step (
      .cur_state  (state_ff),
      .char_byte  (in_byte_ff),
      .next_state (step_state),
      .literal_ok (step_ok)
   );

   always_comb begin
      out_free  = !out_valid_ff || !rsp_stall;
      step_go   = in_valid_ff && (!in_final_ff || out_free);
      req_stall = in_valid_ff && !step_go;

      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         in_byte_in  = req_char_byte;
         in_final_in = req_is_final;
      end

      state_in = state_ff;
      if (step_go) begin
         state_in = in_final_ff ? STATE_RESET : step_state;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_ok_in    = out_ok_ff;
      if (step_go && in_final_ff) begin
         out_valid_in = 1'b1;
         out_ok_in    = step_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
      out_ok_ff   <= out_ok_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_literal_ok = out_ok_ff;

endmodule
